[rtl/core/pesr_pkg.sv]
`default_nettype none
package pesr_pkg;

    localparam int RUN_BITS     = 52;
    localparam int SPACING_BITS = 48;
    localparam int CNT_BITS     = 7;
    localparam logic [SPACING_BITS-1:0] SPACING_RESET = SPACING_BITS'(65536);

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE  = 4'd0;
    localparam op_t OP_LOAD  = 4'd1;
    localparam op_t OP_MXI   = 4'd2;
    localparam op_t OP_MUL   = 4'd3;
    localparam op_t OP_MYI   = 4'd4;
    localparam op_t OP_SQI   = 4'd5;
    localparam op_t OP_SQRT  = 4'd6;
    localparam op_t OP_DNI   = 4'd7;
    localparam op_t OP_DIV   = 4'd8;
    localparam op_t OP_NDONE = 4'd9;
    localparam op_t OP_PXI   = 4'd10;
    localparam op_t OP_DXI   = 4'd11;
    localparam op_t OP_PYI   = 4'd12;
    localparam op_t OP_YDONE = 4'd13;
    localparam op_t OP_OUTV  = 4'd14;
    localparam op_t OP_NEXT  = 4'd15;

    typedef struct packed {
        op_t  op;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic                starts;
        logic [CNT_BITS-1:0] cnt;
        logic                exact_last;
    } status_t;

endpackage
`default_nettype wire

[rtl/core/pesr_datapath.sv]
`default_nettype none
module pesr_datapath
    import pesr_pkg::*;
#(
    parameter int COORD_BITS             = 32,
    parameter int FRAC_BITS              = 16,
    parameter int MAX_POINTS_PER_SEGMENT = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cmd_t                         cmd,
    input  wire logic                         cfg_we,
    input  wire logic [SPACING_BITS-1:0]      cfg_data,
    input  wire logic signed [COORD_BITS-1:0] vertex_x,
    input  wire logic signed [COORD_BITS-1:0] vertex_y,
    input  wire logic                         starts_polyline,
    output status_t                           status,
    output logic signed [COORD_BITS-1:0]      point_x,
    output logic signed [COORD_BITS-1:0]      point_y,
    output logic                              last_of_run,
    output logic                              overflowed
);

    localparam int DW     = COORD_BITS + 1;
    localparam int MW     = RUN_BITS + 1;
    localparam int PW     = DW + MW;
    localparam int SQW    = 2 * DW + 1;
    localparam int RADW   = 2 * RUN_BITS;
    localparam int SAT_SH = 2 * (RUN_BITS - FRAC_BITS);

    logic [SPACING_BITS-1:0]      spacing_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [RUN_BITS-1:0]          run_reg;

    logic signed [COORD_BITS-1:0] sx_reg, sy_reg;
    logic signed [DW-1:0]         dx_reg, dy_reg;
    logic                         starts_reg;
    logic [DW-1:0]                mplier_reg;
    logic [MW-1:0]                mcand_reg;
    logic [PW-1:0]                acc_reg;
    logic [SQW-1:0]               sq_reg;
    logic [RADW-1:0]              rad_reg;
    logic                         sat_reg;
    logic [RUN_BITS-1:0]          root_reg;
    logic [RUN_BITS+1:0]          srem_reg;
    logic [RUN_BITS-1:0]          seg_reg;
    logic [MW-1:0]                t_reg;
    logic [PW-1:0]                num_reg;
    logic [RUN_BITS-1:0]          rem_reg;
    logic [MW-1:0]                quo_reg;
    logic [RUN_BITS-1:0]          div_reg;
    logic [CNT_BITS-1:0]          cnt_reg;
    logic                         exact_reg;
    logic                         ovf_reg;
    logic signed [COORD_BITS-1:0] px_out_reg, py_out_reg;
    logic                         last_reg, ovf_out_reg;

    logic [DW-1:0]       mag_dx, mag_dy;
    logic [RUN_BITS-1:0] sp;
    logic [PW-1:0]       acc_next;
    logic [SQW-1:0]      sq_sum;
    logic                sat;
    logic [RADW-1:0]     rad_init;
    logic [RUN_BITS+2:0] s2, trial;
    logic                sq_ge;
    logic [RUN_BITS-1:0] seg_now, r_now;
    logic [MW-1:0]       len_now;
    logic [MW-1:0]       ds, div_ext;
    logic                dv_ge;
    logic                n_ovf;

    function automatic logic [COORD_BITS-1:0] interp(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [DW-1:0]         d,
        input logic [DW-1:0]                q,
        input logic                         rest
    );
        logic signed [DW:0] v;
        logic signed [DW:0] pe, qe;
        pe = $signed({{2{p[COORD_BITS-1]}}, p});
        qe = $signed({1'b0, q});
        if (!d[DW-1]) begin
            v = pe + qe;
            if (v < 0 && rest)
                v = v + 1;
        end else begin
            v = pe - qe;
            if (v > 0 && rest)
                v = v - 1;
        end
        return v[COORD_BITS-1:0];
    endfunction

    assign mag_dx = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign mag_dy = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
    assign sp = (spacing_reg == '0) ? RUN_BITS'(1) : RUN_BITS'(spacing_reg);

    // shift-add multiplier, multiplier MSB first
    assign acc_next = {acc_reg[PW-2:0], 1'b0} + (mplier_reg[DW-1] ? PW'(mcand_reg) : '0);

    assign sq_sum   = sq_reg + SQW'(acc_reg);
    assign sat      = (sq_sum >> SAT_SH) != '0;
    assign rad_init = RADW'(sq_sum) << (2 * FRAC_BITS);

    // restoring square root, one root bit per cycle
    assign s2    = {srem_reg[RUN_BITS:0], rad_reg[RADW-1:RADW-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign sq_ge = s2 >= trial;

    assign seg_now = sat_reg ? '1 : root_reg;
    assign r_now   = (run_reg > sp) ? sp : run_reg;
    assign len_now = MW'(r_now) + MW'(seg_now);

    // restoring divider, one quotient bit per cycle
    assign ds      = {rem_reg, num_reg[PW-1]};
    assign div_ext = MW'(div_reg);
    assign dv_ge   = ds >= div_ext;

    assign n_ovf = quo_reg > MW'(MAX_POINTS_PER_SEGMENT);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            spacing_reg <= SPACING_RESET;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            run_reg     <= '0;
        end else begin
            if (cfg_we)
                spacing_reg <= cfg_data;
            if (cmd.op == OP_LOAD) begin
                prev_x_reg <= vertex_x;
                prev_y_reg <= vertex_y;
                if (starts_polyline)
                    run_reg <= '0;
            end
            if (cmd.op == OP_NDONE)
                run_reg <= rem_reg;
        end
    end

    always_ff @(posedge clk) begin
        case (cmd.op)
            OP_LOAD: begin
                starts_reg <= starts_polyline;
                sx_reg     <= prev_x_reg;
                sy_reg     <= prev_y_reg;
                dx_reg     <= DW'(vertex_x) - DW'(prev_x_reg);
                dy_reg     <= DW'(vertex_y) - DW'(prev_y_reg);
                if (starts_polyline) begin
                    px_out_reg  <= vertex_x;
                    py_out_reg  <= vertex_y;
                    last_reg    <= 1'b1;
                    ovf_out_reg <= 1'b0;
                end
            end
            OP_MXI: begin
                mplier_reg <= mag_dx;
                mcand_reg  <= MW'(mag_dx);
                acc_reg    <= '0;
            end
            OP_MUL: begin
                acc_reg    <= acc_next;
                mplier_reg <= {mplier_reg[DW-2:0], 1'b0};
            end
            OP_MYI: begin
                sq_reg     <= SQW'(acc_reg);
                mplier_reg <= mag_dy;
                mcand_reg  <= MW'(mag_dy);
                acc_reg    <= '0;
            end
            OP_SQI: begin
                rad_reg  <= rad_init;
                sat_reg  <= sat;
                root_reg <= '0;
                srem_reg <= '0;
            end
            OP_SQRT: begin
                rad_reg  <= {rad_reg[RADW-3:0], 2'b00};
                root_reg <= {root_reg[RUN_BITS-2:0], sq_ge};
                srem_reg <= sq_ge ? (RUN_BITS+2)'(s2 - trial) : (RUN_BITS+2)'(s2);
            end
            OP_DNI: begin
                seg_reg <= seg_now;
                t_reg   <= MW'(sp - r_now);
                num_reg <= PW'(len_now) << (PW - MW);
                rem_reg <= '0;
                quo_reg <= '0;
                div_reg <= sp;
            end
            OP_DIV: begin
                rem_reg <= dv_ge ? RUN_BITS'(ds - div_ext) : RUN_BITS'(ds);
                quo_reg <= {quo_reg[MW-2:0], dv_ge};
                num_reg <= {num_reg[PW-2:0], 1'b0};
            end
            OP_NDONE: begin
                exact_reg <= (rem_reg == '0) && (quo_reg != '0);
                ovf_reg   <= n_ovf;
                cnt_reg   <= n_ovf ? CNT_BITS'(MAX_POINTS_PER_SEGMENT) : quo_reg[CNT_BITS-1:0];
            end
            OP_PXI: begin
                mplier_reg <= mag_dx;
                mcand_reg  <= t_reg;
                acc_reg    <= '0;
            end
            OP_DXI: begin
                // quotient stays below |d|, so the high part is already below seg
                rem_reg <= RUN_BITS'(acc_reg >> DW);
                num_reg <= acc_reg << MW;
                quo_reg <= '0;
                div_reg <= seg_reg;
            end
            OP_PYI: begin
                px_out_reg <= interp(sx_reg, dx_reg, quo_reg[DW-1:0], rem_reg != '0);
                mplier_reg <= mag_dy;
                mcand_reg  <= t_reg;
                acc_reg    <= '0;
            end
            OP_YDONE: begin
                py_out_reg  <= interp(sy_reg, dy_reg, quo_reg[DW-1:0], rem_reg != '0);
                last_reg    <= cmd.last;
                ovf_out_reg <= ovf_reg;
            end
            OP_OUTV: begin
                px_out_reg  <= prev_x_reg;
                py_out_reg  <= prev_y_reg;
                last_reg    <= cmd.last;
                ovf_out_reg <= ovf_reg;
            end
            OP_NEXT: begin
                t_reg <= t_reg + MW'(sp);
            end
            default: begin
            end
        endcase
    end

    assign status.starts     = starts_reg;
    assign status.cnt        = cnt_reg;
    assign status.exact_last = exact_reg && !ovf_reg;

    assign point_x     = px_out_reg;
    assign point_y     = py_out_reg;
    assign last_of_run = last_reg;
    assign overflowed  = ovf_out_reg;

endmodule
`default_nettype wire

[rtl/core/pesr_ctrl.sv]
`default_nettype none
module pesr_ctrl
    import pesr_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    starts_polyline,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam int DW = COORD_BITS + 1;
    localparam int MW = RUN_BITS + 1;
    localparam int SW = $clog2(MW + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MXI   = 5'd1;
    localparam logic [4:0] S_MX    = 5'd2;
    localparam logic [4:0] S_MYI   = 5'd3;
    localparam logic [4:0] S_MY    = 5'd4;
    localparam logic [4:0] S_SQI   = 5'd5;
    localparam logic [4:0] S_SQ    = 5'd6;
    localparam logic [4:0] S_DNI   = 5'd7;
    localparam logic [4:0] S_DN    = 5'd8;
    localparam logic [4:0] S_NDONE = 5'd9;
    localparam logic [4:0] S_PT    = 5'd10;
    localparam logic [4:0] S_PXI   = 5'd11;
    localparam logic [4:0] S_PX    = 5'd12;
    localparam logic [4:0] S_DXI   = 5'd13;
    localparam logic [4:0] S_DX    = 5'd14;
    localparam logic [4:0] S_PYI   = 5'd15;
    localparam logic [4:0] S_PY    = 5'd16;
    localparam logic [4:0] S_DYI   = 5'd17;
    localparam logic [4:0] S_DY    = 5'd18;
    localparam logic [4:0] S_YDONE = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;

    logic [4:0]          state_reg, state_next;
    logic [SW-1:0]       step_reg, step_next;
    logic [CNT_BITS-1:0] k_reg, k_next;
    logic                last_reg, last_next;
    logic                last_now;
    logic                step_done;

    assign last_now  = (k_reg + CNT_BITS'(1)) == status.cnt;
    assign step_done = step_reg == SW'(1);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        cmd.op     = OP_NONE;
        cmd.last   = last_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op    = OP_LOAD;
                    k_next    = '0;
                    last_next = 1'b1;
                    state_next = starts_polyline ? S_OUT : S_MXI;
                end
            end
            S_MXI: begin
                cmd.op = OP_MXI; step_next = SW'(DW); state_next = S_MX;
            end
            S_MX: begin
                cmd.op = OP_MUL; step_next = step_reg - SW'(1);
                if (step_done) state_next = S_MYI;
            end
            S_MYI: begin
                cmd.op = OP_MYI; step_next = SW'(DW); state_next = S_MY;
            end
            S_MY: begin
                cmd.op = OP_MUL; step_next = step_reg - SW'(1);
                if (step_done) state_next = S_SQI;
            end
            S_SQI: begin
                cmd.op = OP_SQI; step_next = SW'(RUN_BITS); state_next = S_SQ;
            end
            S_SQ: begin
                cmd.op = OP_SQRT; step_next = step_reg - SW'(1);
                if (step_done) state_next = S_DNI;
            end
            S_DNI: begin
                cmd.op = OP_DNI; step_next = SW'(MW); state_next = S_DN;
            end
            S_DN: begin
                cmd.op = OP_DIV; step_next = step_reg - SW'(1);
                if (step_done) state_next = S_NDONE;
            end
            S_NDONE: begin
                cmd.op = OP_NDONE; state_next = S_PT;
            end
            S_PT: begin
                last_next = last_now;
                if (status.cnt == '0) begin
                    state_next = S_IDLE;
                end else if (last_now && status.exact_last) begin
                    // multiple lands on the vertex itself
                    cmd.op     = OP_OUTV;
                    cmd.last   = 1'b1;
                    state_next = S_OUT;
                end else begin
                    state_next = S_PXI;
                end
            end
            S_PXI: begin
                cmd.op = OP_PXI; step_next = SW'(DW); state_next = S_PX;
            end
            S_PX: begin
                cmd.op = OP_MUL; step_next = step_reg - SW'(1);
                if (step_done) state_next = S_DXI;
            end
            S_DXI: begin
                cmd.op = OP_DXI; step_next = SW'(DW); state_next = S_DX;
            end
            S_DX: begin
                cmd.op = OP_DIV; step_next = step_reg - SW'(1);
                if (step_done) state_next = S_PYI;
            end
            S_PYI: begin
                cmd.op = OP_PYI; step_next = SW'(DW); state_next = S_PY;
            end
            S_PY: begin
                cmd.op = OP_MUL; step_next = step_reg - SW'(1);
                if (step_done) state_next = S_DYI;
            end
            S_DYI: begin
                cmd.op = OP_DXI; step_next = SW'(DW); state_next = S_DY;
            end
            S_DY: begin
                cmd.op = OP_DIV; step_next = step_reg - SW'(1);
                if (step_done) state_next = S_YDONE;
            end
            S_YDONE: begin
                cmd.op = OP_YDONE; state_next = S_OUT;
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.op     = OP_NEXT;
                    k_next     = k_reg + CNT_BITS'(1);
                    state_next = last_reg ? S_IDLE : S_PT;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            k_reg     <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/polyline_equal_spacing_resampler.sv]
// Start vertex: one word out, valid the cycle after the vertex is taken.
// Other vertices: the segment is first measured
// (two bit-serial squares, 52-step square root, 53-step divide), then each
// interpolated point takes a serial multiply and divide per axis.
// One vertex in flight; in_ready is high only when idle.
// Reset (async, active low): idle, spacing 65536, previous vertex and running length zero.
`default_nettype none
module polyline_equal_spacing_resampler
    import pesr_pkg::*;
#(
    parameter int COORD_BITS             = 32,
    parameter int FRAC_BITS              = 16,
    parameter int MAX_POINTS_PER_SEGMENT = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [SPACING_BITS-1:0]      cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] vertex_x,
    input  wire logic signed [COORD_BITS-1:0] vertex_y,
    input  wire logic                         starts_polyline,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      point_x,
    output logic signed [COORD_BITS-1:0]      point_y,
    output logic                              last_of_run,
    output logic                              overflowed
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    pesr_ctrl #(
        .COORD_BITS(COORD_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .starts_polyline (starts_polyline),
        .in_ready        (in_ready),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .cmd             (cmd)
    );

    pesr_datapath #(
        .COORD_BITS             (COORD_BITS),
        .FRAC_BITS              (FRAC_BITS),
        .MAX_POINTS_PER_SEGMENT (MAX_POINTS_PER_SEGMENT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .vertex_x        (vertex_x),
        .vertex_y        (vertex_y),
        .starts_polyline (starts_polyline),
        .status          (status),
        .point_x         (point_x),
        .point_y         (point_y),
        .last_of_run     (last_of_run),
        .overflowed      (overflowed)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a word is pending");

    a_start_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && starts_polyline |=> out_valid && last_of_run && !overflowed)
        else $error("start vertex not echoed");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_run |=> in_ready)
        else $error("not idle after last word");

endmodule
`default_nettype wire
